// ===== hw/rtl/u8cp_pkg.sv =====
// Shared types and constants for the UTF-8 to code point decoder.
package u8cp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 24;

  localparam logic [ByteW-1:0] AsciiMax = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Lo  = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Hi  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi  = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi  = 8'hFF;

  // current byte plus the three bytes before it
  typedef struct packed {
    logic [ByteW-1:0] b3;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b0;
  } u8cp_win_t;

endpackage

// ===== hw/rtl/u8cp_decode.sv =====
// Combinational decode of one byte window into code point bits.
module u8cp_decode
  import u8cp_pkg::*;
(
  input  u8cp_win_t     win_i,
  output logic [CpW-1:0] cp_o
);

  logic is_ascii, is_l2, is_l3, is_l4;

  assign is_ascii = (win_i.b0 <= AsciiMax);
  assign is_l2    = (win_i.b1 >= Lead2Lo) && (win_i.b1 <= Lead2Hi);
  assign is_l3    = (win_i.b2 >= Lead3Lo) && (win_i.b2 <= Lead3Hi);
  assign is_l4    = (win_i.b3 >= Lead4Lo) && (win_i.b3 <= Lead4Hi);

  always_comb begin
    cp_o = '0;
    if (is_ascii) begin
      cp_o[6:0] = cp_o[6:0] | win_i.b0[6:0];
    end
    if (is_l2) begin
      cp_o[10:6] = cp_o[10:6] | win_i.b1[4:0];
      cp_o[5:0]  = cp_o[5:0]  | win_i.b0[5:0];
    end
    if (is_l3) begin
      cp_o[15:12] = cp_o[15:12] | win_i.b2[3:0];
      cp_o[11:6]  = cp_o[11:6]  | win_i.b1[5:0];
      cp_o[5:0]   = cp_o[5:0]   | win_i.b0[5:0];
    end
    if (is_l4) begin
      cp_o[20:18] = cp_o[20:18] | win_i.b3[2:0];
      cp_o[17:12] = cp_o[17:12] | win_i.b2[5:0];
      cp_o[11:6]  = cp_o[11:6]  | win_i.b1[5:0];
      cp_o[5:0]   = cp_o[5:0]   | win_i.b0[5:0];
    end
  end

endmodule

// ===== hw/rtl/utf8_to_codepoint_decoder.sv =====
// Top level: UTF-8 byte stream to code point stream, one result per byte.
// The input byte is registered into the window register, and its decoded result into the result register.
// Throughput: one byte per cycle unless back-pressured; set by the two-stage register pipeline.
// Back-pressure stalls both stages; each stage refills as the next one drains.
// Reset clears the valid flags and the three-byte history window to zero.
module utf8_to_codepoint_decoder
  import u8cp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [7:0] byte_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [20:0] code_point, [23:21] zero
);

  logic [ByteW-1:0] hist0_q, hist1_q, hist2_q;
  logic             v1_q, v2_q;
  u8cp_win_t        win_q;
  logic [CpW-1:0]   cp_d, cp_q;
  logic             in_xfer, st2_ready, st1_ready;

  assign st2_ready     = !v2_q || m_axis_tready;
  assign st1_ready     = !v1_q || st2_ready;
  assign s_axis_tready = st1_ready;
  assign in_xfer       = s_axis_tvalid && st1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q <= '0;
      hist1_q <= '0;
      hist2_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (in_xfer) begin
        hist0_q <= s_axis_tdata[ByteW-1:0];
        hist1_q <= hist0_q;
        hist2_q <= hist1_q;
      end
      if (st1_ready) begin
        v1_q <= s_axis_tvalid;
      end
      if (st2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      win_q.b0 <= s_axis_tdata[ByteW-1:0];
      win_q.b1 <= hist0_q;
      win_q.b2 <= hist1_q;
      win_q.b3 <= hist2_q;
    end
    if (st2_ready && v1_q) begin
      cp_q <= cp_d;
    end
  end

  u8cp_decode u_decode (
    .win_i (win_q),
    .cp_o  (cp_d)
  );

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {{(OutTdataW-CpW){1'b0}}, cp_q};

`ifndef SYNTHESIS
  a_in_fills_st1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> v1_q)
    else $error("input transfer did not fill stage 1");

  a_st1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && st2_ready |=> v2_q)
    else $error("stage 1 item lost on the way to result register");

  a_ascii_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && (win_q.b0 <= AsciiMax) && (win_q.b1 < Lead2Lo) && (win_q.b2 < Lead2Lo)
      && (win_q.b3 < Lead2Lo) |-> cp_d == CpW'(win_q.b0))
    else $error("plain ASCII byte decoded wrong");

  a_hist_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> win_q.b1 == $past(hist0_q) && hist0_q == win_q.b0)
    else $error("history window out of step with captured byte");
`endif

endmodule
